FILE: sv/ssfe_pkg.sv
// Shared types and constants of the state-switch fade envelope unit.
// Used by ssfe_div, ssfe_ctrl, ssfe_dp and the top level; depends on nothing.
package ssfe_pkg;

    localparam int LEN_W     = 14;
    localparam int FRAC_W    = 16;
    localparam int RATIO_W   = FRAC_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(FRAC_W);

    localparam logic [RATIO_W-1:0] ONE_Q16       = RATIO_W'(65536);
    localparam logic [RATIO_W-1:0] POINT_SIX_Q16 = RATIO_W'(39322);

    localparam logic [LEN_W-1:0] FADE_OUT_LEN_RST = LEN_W'(576);
    localparam logic [LEN_W-1:0] FADE_IN_LEN_RST  = LEN_W'(2880);

    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LEN  = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_FADE_OUT,
        MODE_FADE_IN
    } mode_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECIDE,
        OP_PASS,
        OP_MUL_PREV,
        OP_MUL_X,
        OP_SCALE_OUT,
        OP_SCALE_IN,
        OP_MUL_DIFF,
        OP_BLEND,
        OP_COUNT_OUT,
        OP_COUNT_IN,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_MUL_A,
        ST_SCALE,
        ST_MUL_D,
        ST_BLEND,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic ch;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  need_div;
        logic  div_done;
    } status_t;

endpackage

FILE: sv/ssfe_div.sv
// Serial restoring divider for ramp ratios: floor(num * 2^16 / den), num < den.
// One quotient bit per cycle. Depends on ssfe_pkg.
module ssfe_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ssfe_pkg::LEN_W-1:0]          num,
    input  logic [ssfe_pkg::LEN_W-1:0]          den,
    output logic                                done,
    output logic [ssfe_pkg::FRAC_W-1:0]         quot
);

    logic [ssfe_pkg::LEN_W-1:0]     rem_reg;
    logic [ssfe_pkg::LEN_W-1:0]     den_reg;
    logic [ssfe_pkg::FRAC_W-1:0]    quot_reg;
    logic [ssfe_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;

    logic [ssfe_pkg::LEN_W:0]       shifted;
    logic                           ge;
    logic [ssfe_pkg::LEN_W:0]       diff;

    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ssfe_pkg::DIV_CNT_W'(1));
            if (start)
                cnt_reg <= ssfe_pkg::DIV_STEPS;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[ssfe_pkg::LEN_W-1:0] : shifted[ssfe_pkg::LEN_W-1:0];
            quot_reg <= {quot_reg[ssfe_pkg::FRAC_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: sv/ssfe_ctrl.sv
// Sequencer of the fade envelope: walks one item through decide, divide,
// per-channel multiply steps, counter update and output hand-off. Depends on ssfe_pkg.
module ssfe_ctrl #(
    parameter int CHANNELS = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ssfe_pkg::status_t status,
    output ssfe_pkg::cmd_t    cmd
);

    ssfe_pkg::state_t state_reg, state_next;
    ssfe_pkg::mode_t  mode_reg, mode_next;
    logic             ch_reg, ch_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_ch;

    assign last_ch = (CHANNELS == 1) || ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssfe_pkg::ST_IDLE;
            mode_reg      <= ssfe_pkg::MODE_PASS;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ch_next        = ch_reg;
        out_valid_next = (out_valid_reg && !m_tready);
        cmd.op         = ssfe_pkg::OP_NONE;
        cmd.ch         = ch_reg;
        s_tready       = 1'b0;

        case (state_reg)
            ssfe_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = ssfe_pkg::OP_LOAD;
                    state_next = ssfe_pkg::ST_DECIDE;
                end
            end
            ssfe_pkg::ST_DECIDE:
            begin
                mode_next = status.mode;
                ch_next   = 1'b0;
                if (status.mode == ssfe_pkg::MODE_PASS)
                begin
                    cmd.op     = ssfe_pkg::OP_PASS;
                    state_next = ssfe_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.op     = ssfe_pkg::OP_DECIDE;
                    state_next = status.need_div ? ssfe_pkg::ST_DIV : ssfe_pkg::ST_MUL_A;
                end
            end
            ssfe_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = ssfe_pkg::ST_MUL_A;
            end
            ssfe_pkg::ST_MUL_A:
            begin
                cmd.op = (mode_reg == ssfe_pkg::MODE_FADE_OUT) ? ssfe_pkg::OP_MUL_PREV
                                                               : ssfe_pkg::OP_MUL_X;
                state_next = ssfe_pkg::ST_SCALE;
            end
            ssfe_pkg::ST_SCALE:
            begin
                if (mode_reg == ssfe_pkg::MODE_FADE_OUT)
                begin
                    cmd.op = ssfe_pkg::OP_SCALE_OUT;
                    if (last_ch)
                        state_next = ssfe_pkg::ST_COUNT;
                    else
                    begin
                        ch_next    = 1'b1;
                        state_next = ssfe_pkg::ST_MUL_A;
                    end
                end
                else
                begin
                    cmd.op     = ssfe_pkg::OP_SCALE_IN;
                    state_next = ssfe_pkg::ST_MUL_D;
                end
            end
            ssfe_pkg::ST_MUL_D:
            begin
                cmd.op     = ssfe_pkg::OP_MUL_DIFF;
                state_next = ssfe_pkg::ST_BLEND;
            end
            ssfe_pkg::ST_BLEND:
            begin
                cmd.op = ssfe_pkg::OP_BLEND;
                if (last_ch)
                    state_next = ssfe_pkg::ST_COUNT;
                else
                begin
                    ch_next    = 1'b1;
                    state_next = ssfe_pkg::ST_MUL_A;
                end
            end
            ssfe_pkg::ST_COUNT:
            begin
                cmd.op = (mode_reg == ssfe_pkg::MODE_FADE_OUT) ? ssfe_pkg::OP_COUNT_OUT
                                                               : ssfe_pkg::OP_COUNT_IN;
                state_next = ssfe_pkg::ST_EMIT;
            end
            ssfe_pkg::ST_EMIT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = ssfe_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ssfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    a_div_not_pass: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssfe_pkg::ST_DIV |-> mode_reg != ssfe_pkg::MODE_PASS)
        else $error("divider wait in pass-through mode");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssfe_pkg::ST_EMIT && (!out_valid_reg || m_tready))
        |=> (out_valid_reg && state_reg == ssfe_pkg::ST_IDLE))
        else $error("result not handed to output register");

    a_count_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssfe_pkg::ST_COUNT
        |-> ($past(state_reg) == ssfe_pkg::ST_SCALE || $past(state_reg) == ssfe_pkg::ST_BLEND))
        else $error("counter update without channel work");

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ssfe_pkg::ST_DECIDE && !s_tready))
        else $error("accepted item not followed by decide");

endmodule

FILE: sv/ssfe_dp.sv
// Datapath of the fade envelope: lengths, ramp counters, last outputs, the
// serial ratio divider and one shared multiplier with rounding and saturation.
// Depends on ssfe_pkg and ssfe_div.
module ssfe_dp #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [SAMPLE_BITS-1:0]        sample_left,
    input  logic signed [SAMPLE_BITS-1:0]        sample_right,
    input  logic                                 arm_fade,
    input  logic                                 cfg_we,
    input  logic [ssfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssfe_pkg::LEN_W-1:0]           cfg_data,
    input  ssfe_pkg::cmd_t                       cmd,
    output ssfe_pkg::status_t                    status,
    output logic signed [SAMPLE_BITS-1:0]        out_left,
    output logic signed [SAMPLE_BITS-1:0]        out_right
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = SB + 1;
    localparam int BW = ssfe_pkg::RATIO_W + 1;
    localparam int PW = AW + BW;
    localparam int RW = PW - ssfe_pkg::FRAC_W;
    localparam int SW = SB + 4;

    localparam logic signed [SW-1:0] SMAX = {{5{1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{5{1'b1}}, {(SB-1){1'b0}}};
    localparam logic [PW-1:0]        HALF = PW'(1) << (ssfe_pkg::FRAC_W - 1);

    function automatic logic signed [SB-1:0] sat_fn(input logic signed [SW-1:0] v);
        if (v > SMAX)
            sat_fn = SMAX[SB-1:0];
        else if (v < SMIN)
            sat_fn = SMIN[SB-1:0];
        else
            sat_fn = v[SB-1:0];
    endfunction

    logic [ssfe_pkg::LEN_W-1:0]   out_len_reg, in_len_reg;
    logic [ssfe_pkg::LEN_W-1:0]   out_cnt_reg, out_cnt_next;
    logic [ssfe_pkg::LEN_W-1:0]   in_cnt_reg, in_cnt_next;
    logic signed [SB-1:0]         prev_reg [2];
    logic signed [SB-1:0]         x_reg [2];
    logic signed [SB-1:0]         y_reg [2];
    logic signed [SB-1:0]         out_left_reg, out_right_reg;
    logic [ssfe_pkg::RATIO_W-1:0] ratio_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [AW-1:0]         diff_reg;

    ssfe_pkg::mode_t              mode;
    logic                         gate;
    logic                         need_div;
    logic                         div_start;
    logic                         div_done;
    logic [ssfe_pkg::LEN_W-1:0]   div_num, div_den;
    logic [ssfe_pkg::FRAC_W-1:0]  div_quot;

    logic signed [SB-1:0]         prev_sel, x_sel;
    logic signed [AW-1:0]         a_op;
    logic signed [BW-1:0]         b_op;
    logic signed [PW-1:0]         product;
    logic [PW-1:0]                rnd_full;
    logic signed [RW-1:0]         rnd;
    logic signed [SB-1:0]         scaled;
    logic signed [AW-1:0]         diff_val;
    logic signed [SB-1:0]         blend;

    // ramp selection from the counters as they stand after arming
    always_comb
    begin
        gate = (out_cnt_reg != '0 && out_len_reg != '0) || (in_cnt_reg != '0 && in_len_reg != '0);
        if (!gate)
            mode = ssfe_pkg::MODE_PASS;
        else if (out_cnt_reg != '0)
            mode = ssfe_pkg::MODE_FADE_OUT;
        else if (in_cnt_reg != '0)
            mode = ssfe_pkg::MODE_FADE_IN;
        else
            mode = ssfe_pkg::MODE_PASS;

        if (mode == ssfe_pkg::MODE_FADE_OUT)
        begin
            need_div = out_cnt_reg < out_len_reg;
            div_num  = out_cnt_reg;
            div_den  = out_len_reg;
        end
        else
        begin
            need_div = (mode == ssfe_pkg::MODE_FADE_IN) && in_len_reg != '0
                       && in_cnt_reg < in_len_reg;
            div_num  = in_len_reg - in_cnt_reg;
            div_den  = in_len_reg;
        end
        div_start = (cmd.op == ssfe_pkg::OP_DECIDE) && need_div;
    end

    ssfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign status.mode     = mode;
    assign status.need_div = need_div;
    assign status.div_done = div_done;

    // shared multiplier and the rounding / saturation behind it
    always_comb
    begin
        prev_sel = prev_reg[cmd.ch];
        x_sel    = x_reg[cmd.ch];
        case (cmd.op)
            ssfe_pkg::OP_MUL_PREV:
            begin
                a_op = {prev_sel[SB-1], prev_sel};
                b_op = {1'b0, ratio_reg};
            end
            ssfe_pkg::OP_MUL_X:
            begin
                a_op = {x_sel[SB-1], x_sel};
                b_op = {1'b0, ratio_reg};
            end
            ssfe_pkg::OP_MUL_DIFF:
            begin
                a_op = diff_reg;
                b_op = {1'b0, ssfe_pkg::POINT_SIX_Q16};
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
        product  = a_op * b_op;
        rnd_full = prod_reg + HALF;
        rnd      = rnd_full[PW-1:ssfe_pkg::FRAC_W];
        scaled   = sat_fn({rnd[RW-1], rnd});
        diff_val = {scaled[SB-1], scaled} - {prev_sel[SB-1], prev_sel};
        blend    = sat_fn({{4{prev_sel[SB-1]}}, prev_sel} + {rnd[RW-1], rnd});
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        in_cnt_next  = in_cnt_reg;
        case (cmd.op)
            ssfe_pkg::OP_LOAD:
            begin
                if (arm_fade)
                begin
                    if (out_len_reg != '0)
                    begin
                        out_cnt_next = out_len_reg;
                        in_cnt_next  = '0;
                    end
                    else if (in_len_reg != '0)
                        in_cnt_next = in_len_reg;
                end
            end
            ssfe_pkg::OP_COUNT_OUT:
            begin
                out_cnt_next = out_cnt_reg - 1'b1;
                // fade-out ends: start the fade-in on the next item
                if (out_cnt_reg == ssfe_pkg::LEN_W'(1) && in_cnt_reg == '0)
                    in_cnt_next = in_len_reg;
            end
            ssfe_pkg::OP_COUNT_IN:
            begin
                in_cnt_next = in_cnt_reg - 1'b1;
            end
            default:
            begin
                out_cnt_next = out_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg <= ssfe_pkg::FADE_OUT_LEN_RST;
            in_len_reg  <= ssfe_pkg::FADE_IN_LEN_RST;
            out_cnt_reg <= '0;
            in_cnt_reg  <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == ssfe_pkg::REG_FADE_OUT_LEN)
                out_len_reg <= cfg_data;
            if (cfg_we && cfg_index == ssfe_pkg::REG_FADE_IN_LEN)
                in_len_reg <= cfg_data;
            out_cnt_reg <= out_cnt_next;
            in_cnt_reg  <= in_cnt_next;
            case (cmd.op)
                ssfe_pkg::OP_PASS:
                begin
                    prev_reg[0] <= x_reg[0];
                    if (CHANNELS >= 2)
                        prev_reg[1] <= x_reg[1];
                end
                ssfe_pkg::OP_SCALE_OUT:
                begin
                    prev_reg[cmd.ch] <= scaled;
                end
                ssfe_pkg::OP_BLEND:
                begin
                    prev_reg[cmd.ch] <= blend;
                end
                default:
                begin
                    prev_reg[0] <= prev_reg[0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
            ratio_reg <= {1'b0, div_quot};
        case (cmd.op)
            ssfe_pkg::OP_LOAD:
            begin
                x_reg[0] <= sample_left;
                x_reg[1] <= sample_right;
                y_reg[0] <= '0;
                y_reg[1] <= '0;
            end
            ssfe_pkg::OP_DECIDE:
            begin
                ratio_reg <= (mode == ssfe_pkg::MODE_FADE_OUT) ? ssfe_pkg::ONE_Q16 : '0;
            end
            ssfe_pkg::OP_PASS:
            begin
                y_reg[0] <= x_reg[0];
                if (CHANNELS >= 2)
                    y_reg[1] <= x_reg[1];
            end
            ssfe_pkg::OP_MUL_PREV, ssfe_pkg::OP_MUL_X, ssfe_pkg::OP_MUL_DIFF:
            begin
                prod_reg <= product;
            end
            ssfe_pkg::OP_SCALE_OUT:
            begin
                y_reg[cmd.ch] <= scaled;
            end
            ssfe_pkg::OP_SCALE_IN:
            begin
                diff_reg <= diff_val;
            end
            ssfe_pkg::OP_BLEND:
            begin
                y_reg[cmd.ch] <= blend;
            end
            ssfe_pkg::OP_EMIT:
            begin
                out_left_reg  <= y_reg[0];
                out_right_reg <= y_reg[1];
            end
            default:
            begin
                diff_reg <= diff_reg;
            end
        endcase
    end

    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule

FILE: sv/state_switch_fade_envelope_unit.sv
// Top level of the state-switch fade envelope unit.
// Depends on ssfe_pkg, ssfe_ctrl, ssfe_dp (which holds ssfe_div).
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser: one stereo frame
//   per item, with s_tuser[0] arming a fade-out followed by a fade-in.
//   Results leave on m_tvalid/m_tready/m_tdata, exactly one per input item.
//   Ramp lengths are written on cfg_we/cfg_index/cfg_data (index 0 fade-out
//   length, index 1 fade-in length) while no item is in flight.
// Timing:
//   One item at a time: a pass-through item goes through decide and emit; fade-out
//   adds multiply and scale per channel, fade-in multiply, scale, multiply and blend
//   per channel, both then a counter update; a ratio to divide first runs the serial
//   divider (one quotient bit per cycle). The next item is accepted in the cycle after
//   hand-off; the single shared multiplier sets the channel steps.
// Reset:
//   Lengths return to 576 and 2880, both counters and the last outputs clear.
// Stall:
//   A result waits in the output register; the next item is accepted and
//   worked on, and it waits before its own hand-off until m_tready frees it.
module state_switch_fade_envelope_unit #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample_left, sample_right
    input  logic [0:0]                               s_tuser,   // arm_fade
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // out_left, out_right
    input  logic                                     cfg_we,
    input  logic [ssfe_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ssfe_pkg::LEN_W-1:0]               cfg_data
);

    localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    ssfe_pkg::cmd_t             cmd;
    ssfe_pkg::status_t          status;
    logic signed [SAMPLE_BITS-1:0] out_left, out_right;

    ssfe_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssfe_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_left  (s_tdata[SAMPLE_BITS-1:0]),
        .sample_right (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .arm_fade     (s_tuser[0]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_left     (out_left),
        .out_right    (out_right)
    );

    assign m_tdata = DATA_W'({out_right, out_left});

endmodule
